// ===== sv/sfce_pkg.sv =====
// ----------------------------------------------------------------------------
// sfce_pkg
// Shared constants, types and the CRC-16/MODBUS byte update for the framed
// sample encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sfce_pkg;

    // Channel count, clamped to the supported range of 1 to 8
    localparam int CHANNELS     = 4;
    localparam int USED_CH      = (CHANNELS < 1) ? 1 : ((CHANNELS > 8) ? 8 : CHANNELS);
    localparam int INPUT_FIELDS = 4;
    localparam int SAMPLE_W     = 16;
    localparam int BYTE_W       = 8;

    localparam int DATA_BYTES = 2 * USED_CH;
    localparam int FRAME_LEN  = DATA_BYTES + 2;
    localparam int DATA_W     = DATA_BYTES * BYTE_W;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Byte position within a frame
    localparam int IDX_W = $clog2(FRAME_LEN);
    typedef logic [IDX_W-1:0] idx_t;
    localparam idx_t IDX_FIRST  = '0;
    localparam idx_t IDX_CRC_LO = idx_t'(DATA_BYTES);
    localparam idx_t IDX_LAST   = idx_t'(FRAME_LEN - 1);

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [DATA_W-1:0] frame_data_t;
    typedef logic [15:0]       crc_t;

    // Reflected CRC-16 update over one byte, LSB first
    function automatic crc_t crc_byte(input crc_t crc, input logic [7:0] b);
        crc_t c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/sfce_front.sv =====
// ----------------------------------------------------------------------------
// sfce_front
// Input stage: accepts a sample item and packs it into the frame data word,
// low byte first per channel; channels past the inputs are sent as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sfce_front (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire signed [15:0]    s_channel_0,
    input  wire signed [15:0]    s_channel_1,
    input  wire signed [15:0]    s_channel_2,
    input  wire signed [15:0]    s_channel_3,
    output logic                 q_valid,
    input  wire                  q_ready,
    output sfce_pkg::frame_data_t q_data
);

    logic [sfce_pkg::SAMPLE_W-1:0] in_ch [sfce_pkg::INPUT_FIELDS];
    sfce_pkg::frame_data_t         packed_data;
    sfce_pkg::frame_data_t         data_reg;
    logic                          valid_reg;

    assign in_ch[0] = unsigned'(s_channel_0);
    assign in_ch[1] = unsigned'(s_channel_1);
    assign in_ch[2] = unsigned'(s_channel_2);
    assign in_ch[3] = unsigned'(s_channel_3);

    // Pack samples in channel order
    for (genvar gi = 0; gi < sfce_pkg::USED_CH; gi++) begin : g_pack
        if (gi < sfce_pkg::INPUT_FIELDS) begin : g_in
            assign packed_data[gi*sfce_pkg::SAMPLE_W +: sfce_pkg::SAMPLE_W] = in_ch[gi];
        end else begin : g_zero
            assign packed_data[gi*sfce_pkg::SAMPLE_W +: sfce_pkg::SAMPLE_W] = '0;
        end
    end

    // One-entry pipeline register, full rate unless the queue stalls it
    assign s_ready = !valid_reg || q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            data_reg <= packed_data;
        end
    end

    assign q_valid = valid_reg;
    assign q_data  = data_reg;

endmodule

`default_nettype wire

// ===== sv/sfce_queue.sv =====
// ----------------------------------------------------------------------------
// sfce_queue
// Short FIFO of packed frame words between the input stage and the
// serialiser, so each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module sfce_queue (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        wr_valid,
    output logic                       wr_ready,
    input  wire sfce_pkg::frame_data_t wr_data,
    output logic                       rd_valid,
    input  wire                        rd_ready,
    output sfce_pkg::frame_data_t      rd_data
);

    sfce_pkg::frame_data_t             mem_reg [sfce_pkg::QDEPTH];
    logic [sfce_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [sfce_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [sfce_pkg::QCNT_W-1:0]       count_reg;
    logic [sfce_pkg::QCNT_W-1:0]       count_next;
    logic                              do_wr;
    logic                              do_rd;

    assign wr_ready = (count_reg != sfce_pkg::QCNT_W'(sfce_pkg::QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    assign do_wr = wr_valid && wr_ready;
    assign do_rd = rd_valid && rd_ready;

    // Occupancy
    always_comb begin
        count_next = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sfce_back.sv =====
// ----------------------------------------------------------------------------
// sfce_back
// Serialiser: sends the data bytes of a frame one per cycle while the output
// is free, folding each into the running CRC, then the CRC low and high bytes with the last flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sfce_back (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        q_valid,
    output logic                       q_ready,
    input  wire sfce_pkg::frame_data_t q_data,
    output logic                       m_valid,
    input  wire                        m_ready,
    output logic [7:0]                 m_frame_byte,
    output logic                       m_last_byte
);

    sfce_pkg::frame_data_t word_reg;
    sfce_pkg::crc_t        crc_reg;
    sfce_pkg::idx_t        idx_reg;
    logic                  busy_reg;
    logic                  out_valid_reg;
    logic [7:0]            out_byte_reg;
    logic                  out_last_reg;

    logic                  out_free;
    logic                  emit;
    logic                  emit_last;
    logic                  load;
    logic [7:0]            cur_byte;

    assign out_free  = !out_valid_reg || m_ready;
    assign emit      = busy_reg && out_free;
    assign emit_last = emit && (idx_reg == sfce_pkg::IDX_LAST);
    assign load      = q_valid && (!busy_reg || emit_last);
    assign q_ready   = !busy_reg || emit_last;

    // Byte at the current frame position
    always_comb begin
        if (idx_reg == sfce_pkg::IDX_CRC_LO) begin
            cur_byte = crc_reg[7:0];
        end else if (idx_reg == sfce_pkg::IDX_LAST) begin
            cur_byte = crc_reg[15:8];
        end else begin
            cur_byte = word_reg[7:0];
        end
    end

    // Frame sequencing and running CRC
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= sfce_pkg::IDX_FIRST;
        end else if (load) begin
            busy_reg <= 1'b1;
            idx_reg  <= sfce_pkg::IDX_FIRST;
        end else if (emit) begin
            if (emit_last) begin
                busy_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 1'b1;
        end
        if (load) begin
            word_reg <= q_data;
            crc_reg  <= sfce_pkg::CRC_INIT;
        end else if (emit && (idx_reg < sfce_pkg::IDX_CRC_LO)) begin
            word_reg <= word_reg >> sfce_pkg::BYTE_W;
            crc_reg  <= sfce_pkg::crc_byte(crc_reg, cur_byte);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (emit) begin
            out_byte_reg <= cur_byte;
            out_last_reg <= (idx_reg == sfce_pkg::IDX_LAST);
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_frame_byte = out_byte_reg;
    assign m_last_byte  = out_last_reg;

endmodule

`default_nettype wire

// ===== sv/scope_frame_crc16_encoder.sv =====
// ----------------------------------------------------------------------------
// scope_frame_crc16_encoder
// Framed sample encoder: four 16-bit samples in, a ten-byte frame out with a
// CRC-16/MODBUS trailer, last byte flagged.
// ----------------------------------------------------------------------------
// Path: an accepted item passes the input register, the queue, the serialiser
//   word register and its output register before its first byte is presented.
// Throughput: one byte a cycle while m_ready allows, through the single output register;
//   the next item loads as a frame's last byte goes, and two items can wait in the queue.
// Reset: synchronous active-low aresetn clears all handshake and sequencing
//   state; data registers are not reset.
`default_nettype none

module scope_frame_crc16_encoder (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  wire signed [15:0] s_channel_0,
    input  wire signed [15:0] s_channel_1,
    input  wire signed [15:0] s_channel_2,
    input  wire signed [15:0] s_channel_3,
    output logic              m_valid,
    input  wire               m_ready,
    output logic [7:0]        m_frame_byte,
    output logic              m_last_byte
);

    logic                  fq_valid;
    logic                  fq_ready;
    sfce_pkg::frame_data_t fq_data;
    logic                  qb_valid;
    logic                  qb_ready;
    sfce_pkg::frame_data_t qb_data;

    sfce_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_channel_0 (s_channel_0),
        .s_channel_1 (s_channel_1),
        .s_channel_2 (s_channel_2),
        .s_channel_3 (s_channel_3),
        .q_valid     (fq_valid),
        .q_ready     (fq_ready),
        .q_data      (fq_data)
    );

    sfce_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    sfce_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (qb_valid),
        .q_ready      (qb_ready),
        .q_data       (qb_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_last_byte  (m_last_byte)
    );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: regression bench for scope_frame_crc16_encoder
// Drives four-sample items through the valid/ready input with random gaps.
// Rebuilds each expected frame (sample bytes low first, CRC-16/MODBUS trailer,
// flag on the final byte) and checks every output byte in order. The output
// side stalls at random, and once holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 147;
    localparam int HOLD_CYCLES  = 150;
    localparam int IDLE_PCT     = 29;

    // One expected output byte
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    // Frame predictor and the bytes still owed by the block
    class crc_frame_scoreboard;
        frame_byte_t pending_frame_bytes[$];
        int          byte_mismatches;

        function new();
            byte_mismatches = 0;
        endfunction

        // Build the frame for one accepted item and queue its bytes
        function void note_samples(input logic [15:0] c0, input logic [15:0] c1,
                                   input logic [15:0] c2, input logic [15:0] c3);
            logic [15:0] samples [8];
            logic [7:0]  data_bytes [16];
            logic [15:0] crc;
            logic        fb;
            frame_byte_t fbyte;
            samples = '{default: 16'h0000};
            samples[0] = c0;
            samples[1] = c1;
            samples[2] = c2;
            samples[3] = c3;
            crc = sfce_pkg::CRC_INIT;
            for (int i = 0; i < sfce_pkg::USED_CH; i++) begin
                data_bytes[2*i]   = samples[i][7:0];
                data_bytes[2*i+1] = samples[i][15:8];
            end
            // Reflected CRC, one bit at a time, LSB first
            for (int i = 0; i < 2 * sfce_pkg::USED_CH; i++) begin
                for (int j = 0; j < 8; j++) begin
                    fb  = crc[0] ^ data_bytes[i][j];
                    crc = crc >> 1;
                    if (fb) begin
                        crc = crc ^ sfce_pkg::CRC_POLY;
                    end
                end
            end
            for (int i = 0; i < 2 * sfce_pkg::USED_CH; i++) begin
                fbyte.data = data_bytes[i];
                fbyte.last = 1'b0;
                pending_frame_bytes.push_back(fbyte);
            end
            fbyte.data = crc[7:0];
            fbyte.last = 1'b0;
            pending_frame_bytes.push_back(fbyte);
            fbyte.data = crc[15:8];
            fbyte.last = 1'b1;
            pending_frame_bytes.push_back(fbyte);
        endfunction

        // Compare one accepted output byte with the oldest expectation
        function void check_frame_byte(input logic [7:0] data, input logic last);
            frame_byte_t want;
            if (pending_frame_bytes.size() == 0) begin
                $display("%0t: unexpected byte: expected none, actual data=%02h last=%0b",
                         $time, data, last);
                byte_mismatches++;
                return;
            end
            want = pending_frame_bytes.pop_front();
            if (want.data !== data) begin
                $display("%0t: frame_byte mismatch: expected %02h, actual %02h",
                         $time, want.data, data);
                byte_mismatches++;
            end
            if (want.last !== last) begin
                $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                         $time, want.last, last);
                byte_mismatches++;
            end
        endfunction

        function int pending();
            return pending_frame_bytes.size();
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic signed [15:0] s_channel_0 = '0;
    logic signed [15:0] s_channel_1 = '0;
    logic signed [15:0] s_channel_2 = '0;
    logic signed [15:0] s_channel_3 = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [7:0]        m_frame_byte;
    logic              m_last_byte;

    // Traffic shaping, written at the clock edge
    logic steady = 1'b0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int   hold_cnt = 0;

    crc_frame_scoreboard frames = new();

    scope_frame_crc16_encoder i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_channel_0  (s_channel_0),
        .s_channel_1  (s_channel_1),
        .s_channel_2  (s_channel_2),
        .s_channel_3  (s_channel_3),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_last_byte  (m_last_byte)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Output side: check accepted bytes, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            frames.check_frame_byte(m_frame_byte, m_last_byte);
        end
        if (hold_cnt > 0) begin
            m_ready  <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req && !hold_done) begin
            // long hold-off so the block backs up and drops s_ready
            m_ready   <= 1'b0;
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Offer one item, with random gaps first, and wait for it to be taken
    task automatic send_samples(input logic [15:0] c0, input logic [15:0] c1,
                                input logic [15:0] c2, input logic [15:0] c3);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_channel_0 <= c0;
        s_channel_1 <= c1;
        s_channel_2 <= c2;
        s_channel_3 <= c3;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        frames.note_samples(c0, c1, c2, c3);
    endtask

    // Mostly uniform samples, some corner values
    function automatic logic [15:0] pick_sample();
        logic [15:0] corners [7];
        corners = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001, 16'hFF00, 16'h00FF};
        if ($urandom_range(99) < 30) begin
            return corners[3'($urandom_range(6))];
        end
        return 16'($urandom());
    endfunction

    initial begin
        int waited;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, byte patterns, one hot channel at a time
        send_samples(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_samples(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_samples(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_samples(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_samples(16'h0001, 16'h0001, 16'h0001, 16'h0001);
        send_samples(16'h0102, 16'h0304, 16'h0506, 16'h0708);
        send_samples(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        send_samples(16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
        send_samples(16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
        send_samples(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        send_samples(16'h00FF, 16'hFF00, 16'h00FF, 16'hFF00);
        send_samples(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        send_samples(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001);

        // Random: hold-off early, a stretch with no gaps on either side
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 20) begin
                hold_req <= 1'b1;
            end
            if (n == 70) begin
                steady <= 1'b1;
            end
            if (n == 110) begin
                steady <= 1'b0;
            end
            send_samples(pick_sample(), pick_sample(), pick_sample(), pick_sample());
        end
        s_valid <= 1'b0;

        // Drain, then allow for the block's latency
        waited = 0;
        while (frames.pending() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (20) @(posedge aclk);

        if (frames.pending() != 0) begin
            $display("%0t: %0d bytes outstanding: expected %02h, actual none",
                     $time, frames.pending(), frames.pending_frame_bytes[0].data);
        end
        if (frames.byte_mismatches == 0 && frames.pending() == 0) begin
            $display("scope_frame_crc16_encoder regression: pass");
        end else begin
            $display("scope_frame_crc16_encoder regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2ms;
        $display("%0t: timeout", $time);
        $display("scope_frame_crc16_encoder regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
sv/sfce_pkg.sv
sv/sfce_front.sv
sv/sfce_queue.sv
sv/sfce_back.sv
sv/scope_frame_crc16_encoder.sv
tb/tb.sv
